// ===== hdl/pipc_pkg.sv =====
`default_nettype none

package pipc_pkg;

	localparam int PIPC_MAX_VERTICES = 64;
	localparam int PIPC_COORD_BITS   = 16;

	// opcode field
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// status field
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// control that travels with each request down the chain
	typedef struct packed {
		logic valid;
		logic query;
		logic parity;
		logic status;
	} pipc_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/point_in_polygon_crossing_top.sv =====
// Point-in-polygon test by upward ray crossing.
// Input channel (in_valid/in_ready): opcode, coord_x, coord_y. An add request
// appends a vertex to the polygon; a query request asks whether the point is
// inside. Output channel (out_valid/out_ready): inside_res, status, exactly one
// result per request, in request order.
// Each vertex lives in one cell of a chain of MAX_VERTICES cells. A request
// walks the chain, two register stages per cell (multiply, then sum and
// compare), and each cell toggles the running parity when the edge from its
// vertex to the next one (or back to the first) is crossed.
// Throughput: one request per cycle unless the receiver stalls; the chain
// streams requests back to back.
// A full store drops an add and reports status 1.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready drops until the result is taken.
// Reset clears the vertex count and empties the chain; vertex storage is not
// cleared, only entries below the count are ever used.
`default_nettype none

module point_in_polygon_crossing_top import pipc_pkg::*; #(
	parameter int MAX_VERTICES = PIPC_MAX_VERTICES,
	parameter int COORD_BITS   = PIPC_COORD_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  opcode,
	input  wire logic [COORD_BITS-1:0] coord_x,
	input  wire logic [COORD_BITS-1:0] coord_y,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       inside_res,
	output logic                       status
);

	localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTICES);

	logic [CNT_BITS-1:0] count_q;
	logic                en, in_fire, full, add_ok;
	pipc_ctl_t           entry_ctl;

	pipc_ctl_t                    ctl_c [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] qx_c  [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] qy_c  [MAX_VERTICES+1];
	logic        [CNT_BITS-1:0]   n_c   [MAX_VERTICES+1];
	logic signed [COORD_BITS-1:0] vx    [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] vy    [MAX_VERTICES];

	assign en       = !ctl_c[MAX_VERTICES].valid || out_ready;
	assign in_ready = en;
	assign in_fire  = in_valid && in_ready;
	assign full     = count_q == CNT_MAX;
	assign add_ok   = in_fire && opcode == OP_ADD && !full;

	always_comb begin
		entry_ctl        = '0;
		entry_ctl.valid  = in_fire;
		entry_ctl.query  = opcode == OP_QUERY;
		entry_ctl.parity = 1'b0;
		entry_ctl.status = (opcode == OP_ADD && full) ? STATUS_FULL : STATUS_OK;
	end

	assign ctl_c[0] = entry_ctl;
	assign qx_c[0]  = $signed(coord_x);
	assign qy_c[0]  = $signed(coord_y);
	assign n_c[0]   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		logic signed [COORD_BITS-1:0] nx, ny;

		if (k == MAX_VERTICES - 1) begin : g_last
			assign nx = vx[0];
			assign ny = vy[0];
		end else begin : g_mid
			assign nx = vx[k+1];
			assign ny = vy[k+1];
		end

		pipc_cell #(
			.COORD_BITS(COORD_BITS),
			.CNT_BITS  (CNT_BITS),
			.INDEX     (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.wr_en  (add_ok),
			.wr_idx (count_q),
			.wr_x   ($signed(coord_x)),
			.wr_y   ($signed(coord_y)),
			.nxt_x  (nx),
			.nxt_y  (ny),
			.first_x(vx[0]),
			.first_y(vy[0]),
			.vert_x (vx[k]),
			.vert_y (vy[k]),
			.ctl_in (ctl_c[k]),
			.qx_in  (qx_c[k]),
			.qy_in  (qy_c[k]),
			.n_in   (n_c[k]),
			.ctl_out(ctl_c[k+1]),
			.qx_out (qx_c[k+1]),
			.qy_out (qy_c[k+1]),
			.n_out  (n_c[k+1])
		);
	end

	assign out_valid  = ctl_c[MAX_VERTICES].valid;
	assign inside_res = ctl_c[MAX_VERTICES].query & ctl_c[MAX_VERTICES].parity;
	assign status     = ctl_c[MAX_VERTICES].status;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("vertex count beyond store depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance vertex count");

	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(inside_res && status))
		else $error("dropped add reported as inside");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && opcode == OP_ADD && full) |=> count_q == CNT_MAX)
		else $error("add to full store changed count");

endmodule

`default_nettype wire

// ===== hdl/pipc_cell.sv =====
`default_nettype none

module pipc_cell import pipc_pkg::*; #(
	parameter int COORD_BITS = PIPC_COORD_BITS,
	parameter int CNT_BITS   = 7,
	parameter int INDEX      = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         wr_en,
	input  wire logic        [CNT_BITS-1:0]   wr_idx,
	input  wire logic signed [COORD_BITS-1:0] wr_x,
	input  wire logic signed [COORD_BITS-1:0] wr_y,
	input  wire logic signed [COORD_BITS-1:0] nxt_x,
	input  wire logic signed [COORD_BITS-1:0] nxt_y,
	input  wire logic signed [COORD_BITS-1:0] first_x,
	input  wire logic signed [COORD_BITS-1:0] first_y,
	output logic signed      [COORD_BITS-1:0] vert_x,
	output logic signed      [COORD_BITS-1:0] vert_y,
	input  wire pipc_ctl_t                    ctl_in,
	input  wire logic signed [COORD_BITS-1:0] qx_in,
	input  wire logic signed [COORD_BITS-1:0] qy_in,
	input  wire logic        [CNT_BITS-1:0]   n_in,
	output pipc_ctl_t                         ctl_out,
	output logic signed      [COORD_BITS-1:0] qx_out,
	output logic signed      [COORD_BITS-1:0] qy_out,
	output logic             [CNT_BITS-1:0]   n_out
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam logic [CNT_BITS-1:0] IDX_SELF = CNT_BITS'(INDEX);
	localparam logic [CNT_BITS-1:0] IDX_NEXT = CNT_BITS'(INDEX + 1);

	logic signed [COORD_BITS-1:0] vert_x_q, vert_y_q;
	logic signed [COORD_BITS-1:0] sx, sy;
	logic                         use_next, act;
	logic signed [DW-1:0]         dx, dy, a, b;
	logic signed [PW-1:0]         p1, p2;
	logic                         pos, neg, rng;

	pipc_ctl_t                    ctl_s1, ctl_s2, ctl_nxt;
	logic signed [COORD_BITS-1:0] qx_s1, qy_s1, qx_s2, qy_s2;
	logic        [CNT_BITS-1:0]   n_s1, n_s2;
	logic                         act_s1, pos_s1, rng_s1;
	logic signed [PW-1:0]         p1_s1, p2_s1;
	logic signed [SW-1:0]         lhs;
	logic                         hit;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IDX_SELF) begin
			vert_x_q <= wr_x;
			vert_y_q <= wr_y;
		end
	end

	assign vert_x = vert_x_q;
	assign vert_y = vert_y_q;

	// edge runs from the next stored vertex (or the first one, closing) to this one
	always_comb begin
		use_next = IDX_NEXT < n_in;
		sx       = use_next ? nxt_x : first_x;
		sy       = use_next ? nxt_y : first_y;
		act      = ctl_in.valid && ctl_in.query && (IDX_SELF < n_in);
		dx       = $signed({vert_x_q[COORD_BITS-1], vert_x_q}) - $signed({sx[COORD_BITS-1], sx});
		dy       = $signed({vert_y_q[COORD_BITS-1], vert_y_q}) - $signed({sy[COORD_BITS-1], sy});
		a        = $signed({qx_in[COORD_BITS-1], qx_in}) - $signed({sx[COORD_BITS-1], sx});
		b        = $signed({sy[COORD_BITS-1], sy}) - $signed({qy_in[COORD_BITS-1], qy_in});
		p1       = b * dx;
		p2       = a * dy;
		pos      = dx > 0;
		neg      = dx < 0;
		if (pos) begin
			rng = (a >= 0) && (a <= dx);
		end else if (neg) begin
			rng = (a <= 0) && (a >= dx);
		end else begin
			rng = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1  <= qx_in;
			qy_s1  <= qy_in;
			n_s1   <= n_in;
			act_s1 <= act;
			pos_s1 <= pos;
			rng_s1 <= rng;
			p1_s1  <= p1;
			p2_s1  <= p2;
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			n_s2   <= n_s1;
		end
	end

	// height at the query x lies strictly above the point
	always_comb begin
		lhs            = $signed({p1_s1[PW-1], p1_s1}) + $signed({p2_s1[PW-1], p2_s1});
		hit            = act_s1 && rng_s1 && (pos_s1 ? (lhs > 0) : (lhs < 0));
		ctl_nxt        = ctl_s1;
		ctl_nxt.parity = ctl_s1.parity ^ hit;
	end

	assign ctl_out = ctl_s2;
	assign qx_out  = qx_s2;
	assign qy_out  = qy_s2;
	assign n_out   = n_s2;

endmodule

`default_nettype wire
